// ----- rtl/core/mpu_pkg.sv -----
// shared types, constants and permission helper for the memory protection unit
package mpu_pkg;

  localparam int unsigned REGION_COUNT = 8;
  localparam int unsigned IDX_W = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  localparam logic [31:0] LOW_BITS_MASK = 32'h0000_001F;
  localparam logic [31:0] CODE_LIMIT    = 32'h2000_0000;
  localparam logic [7:0]  BYTE_MASK     = 8'hFF;

  // commands
  localparam logic [1:0] CMD_CHECK = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // register selects
  localparam logic [3:0] SEL_TYPE    = 4'd0;
  localparam logic [3:0] SEL_CTRL    = 4'd1;
  localparam logic [3:0] SEL_RNR     = 4'd2;
  localparam logic [3:0] SEL_RBAR    = 4'd3;
  localparam logic [3:0] SEL_RLAR    = 4'd4;
  localparam logic [3:0] SEL_RBAR_A1 = 4'd5;
  localparam logic [3:0] SEL_RLAR_A1 = 4'd6;
  localparam logic [3:0] SEL_RBAR_A2 = 4'd7;
  localparam logic [3:0] SEL_RLAR_A2 = 4'd8;
  localparam logic [3:0] SEL_RBAR_A3 = 4'd9;
  localparam logic [3:0] SEL_RLAR_A3 = 4'd10;
  localparam logic [3:0] SEL_MAIR0   = 4'd11;
  localparam logic [3:0] SEL_MAIR1   = 4'd12;

  // access permission codes
  localparam logic [1:0] AP_PRIV_RW = 2'd0;
  localparam logic [1:0] AP_ALL_RW  = 2'd1;
  localparam logic [1:0] AP_PRIV_RO = 2'd2;
  localparam logic [1:0] AP_ALL_RO  = 2'd3;

  // fault kinds
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_INSTR = 2'd1;
  localparam logic [1:0] FAULT_DATA  = 2'd2;

  typedef logic [IDX_W-1:0] mpu_idx_t;

  // match record handed down the row of region cells
  typedef struct packed {
    logic       valid;
    logic       hit0;
    mpu_idx_t   idx0;
    logic [2:0] perm0;
    logic [2:0] attr0;
    logic       hit1;
    mpu_idx_t   idx1;
    logic [2:0] perm1;
  } mpu_carrier_t;

  typedef struct packed {
    logic        base_we;
    logic        limit_we;
    logic [31:0] data;
  } mpu_cell_wr_t;

  // permission check of one byte; perm is {ap, xn}
  function automatic logic mpu_byte_ok(input logic       hit,
                                       input logic [2:0] perm,
                                       input logic       fetch,
                                       input logic       priv,
                                       input logic       wr,
                                       input logic       code_region,
                                       input logic       privdef);
    logic ok;
    ok = 1'b0;
    if (!hit) begin
      ok = privdef && priv && (code_region || !fetch);
    end else if (fetch && perm[0]) begin
      ok = 1'b0;
    end else begin
      case (perm[2:1])
        AP_PRIV_RW: ok = priv;
        AP_ALL_RW:  ok = 1'b1;
        AP_PRIV_RO: ok = priv && !wr;
        AP_ALL_RO:  ok = !wr;
        default:    ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

// ----- rtl/core/mpu_region_cell.sv -----
// one region cell: holds base and limit words and updates the passing match record
module mpu_region_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mpu_pkg::mpu_idx_t     idx_i,
  input  mpu_pkg::mpu_cell_wr_t wr_i,
  input  logic [31:0]           start_addr_i,
  input  logic [31:0]           end_addr_i,
  input  mpu_pkg::mpu_carrier_t carrier_i,
  output mpu_pkg::mpu_carrier_t carrier_o,
  output logic [31:0]           base_o,
  output logic [31:0]           limit_o
);
  import mpu_pkg::*;

  logic [31:0]  base_q;
  logic [31:0]  limit_q;
  logic [31:0]  lo;
  logic [31:0]  hi;
  logic         match_start;
  logic         match_end;
  mpu_carrier_t carrier_d;
  mpu_carrier_t carrier_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= '0;
    end else begin
      if (wr_i.base_we) begin
        base_q <= wr_i.data;
      end
      if (wr_i.limit_we) begin
        limit_q <= wr_i.data;
      end
    end
  end

  assign lo = base_q & ~LOW_BITS_MASK;
  assign hi = limit_q | LOW_BITS_MASK;

  assign match_start = limit_q[0] && (start_addr_i >= lo) && (start_addr_i <= hi);
  assign match_end   = limit_q[0] && (end_addr_i >= lo) && (end_addr_i <= hi);

  // higher cells come first, so the first hit recorded wins
  always_comb begin
    carrier_d = carrier_i;
    if (!carrier_i.hit0 && match_start) begin
      carrier_d.hit0  = 1'b1;
      carrier_d.idx0  = idx_i;
      carrier_d.perm0 = base_q[2:0];
      carrier_d.attr0 = limit_q[3:1];
    end
    if (!carrier_i.hit1 && match_end) begin
      carrier_d.hit1  = 1'b1;
      carrier_d.idx1  = idx_i;
      carrier_d.perm1 = base_q[2:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_q <= '0;
    end else begin
      carrier_q <= carrier_d;
    end
  end

  assign carrier_o = carrier_q;
  assign base_o    = base_q;
  assign limit_o   = limit_q;

endmodule

// ----- rtl/core/memory_protection_unit.sv -----
// memory protection unit top level: request intake, register file and check resolution
//
// Requests are commands: a request is taken at a rising edge where start is high and
// busy is low. command_i selects an access check, a register read or a register write.
// Each request gives exactly one result, shown for one cycle with result_valid_o high;
// the receiver has no way to hold it off and must take it in that cycle.
// Register read and write: the request is registered, then the result registers are
// written and the strobe shows; busy is high for one cycle and drops with the strobe.
// Access check: the match record runs down the row of REGION_COUNT region cells and
// is registered in each cell; permissions are then resolved from the record leaving
// the lowest cell and registered into the result registers with the strobe. Busy stays
// high until the record leaves the lowest cell, so no new request is taken meanwhile.
// Result outputs other than the strobe hold their last values between results.
// Reset clears all region words, control, region number and attribute words: the unit
// is disabled, every check is allowed and no request is in flight.
module memory_protection_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] address_i,
  input  logic [15:0] access_size_i,
  input  logic        write_access_i,
  input  logic        instr_fetch_i,
  input  logic        privileged_i,
  input  logic        fault_handler_i,
  input  logic [3:0]  register_select_i,
  input  logic [31:0] write_data_i,
  output logic        result_valid_o,
  output logic        allowed_o,
  output logic [1:0]  fault_type_o,
  output logic [31:0] fault_address_o,
  output logic        fault_address_valid_o,
  output logic [31:0] read_data_o,
  output logic [7:0]  attribute_byte_o
);
  import mpu_pkg::*;

  localparam logic [IDX_W+1:0] RC_EXT = (IDX_W+2)'(REGION_COUNT);

  // request registers
  logic        busy_q;
  logic        launch_q;
  logic        reg_op_q;
  logic [1:0]  cmd_q;
  logic [31:0] addr_q;
  logic [31:0] end_q;
  logic        wrap_q;
  logic        size_zero_q;
  logic        size_one_q;
  logic        wr_q;
  logic        fetch_q;
  logic        priv_q;
  logic        hf_q;
  logic [3:0]  sel_q;
  logic [31:0] data_q;
  logic [32:0] end_sum;

  // architectural registers
  logic [2:0]  ctrl_q;
  mpu_idx_t    rnr_q;
  logic [31:0] mair0_q;
  logic [31:0] mair1_q;

  // result registers
  logic        res_valid_q;
  logic        allowed_q;
  logic [1:0]  ftype_q;
  logic [31:0] faddr_q;
  logic        fvalid_q;
  logic [31:0] rdata_q;
  logic [7:0]  attr_q;

  mpu_carrier_t chain [REGION_COUNT+1];
  mpu_cell_wr_t cell_wr [REGION_COUNT];
  logic [31:0]  base_w [REGION_COUNT];
  logic [31:0]  limit_w [REGION_COUNT];

  logic         accept;
  logic         fin;

  // register decode
  logic          is_region;
  logic          is_rbar;
  logic [1:0]    alias_off;
  logic [IDX_W+1:0] ridx;
  logic          ridx_ok;
  logic [31:0]   region_rd;
  logic [31:0]   rd_word;

  // check resolution
  logic          bypass;
  logic          ok0;
  logic          ok1;
  logic          spans;
  logic          check_ok;
  logic [31:0]   mair_word;
  logic [31:0]   mair_shift;
  logic [7:0]    attr_byte;

  assign accept  = start && !busy_q;
  assign busy    = busy_q;
  assign end_sum = {1'b0, address_i} + {17'b0, access_size_i} - 33'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      reg_op_q <= 1'b0;
    end else begin
      launch_q <= accept && (command_i == CMD_CHECK);
      reg_op_q <= accept && (command_i != CMD_CHECK);
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fin || reg_op_q) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q       <= command_i;
      addr_q      <= address_i;
      end_q       <= end_sum[31:0];
      wrap_q      <= end_sum[32];
      size_zero_q <= (access_size_i == 16'd0);
      size_one_q  <= (access_size_i == 16'd1);
      wr_q        <= write_access_i;
      fetch_q     <= instr_fetch_i;
      priv_q      <= privileged_i;
      hf_q        <= fault_handler_i;
      sel_q       <= register_select_i;
      data_q      <= write_data_i;
    end
  end

  // row of region cells, highest region first
  always_comb begin
    chain[REGION_COUNT]       = '0;
    chain[REGION_COUNT].valid = launch_q;
  end

  for (genvar i = 0; i < REGION_COUNT; i++) begin : g_cell
    always_comb begin
      cell_wr[i].data     = data_q;
      cell_wr[i].base_we  = reg_op_q && (cmd_q == CMD_WRITE) && is_region && ridx_ok &&
                            is_rbar && (ridx[IDX_W-1:0] == IDX_W'(i));
      cell_wr[i].limit_we = reg_op_q && (cmd_q == CMD_WRITE) && is_region && ridx_ok &&
                            !is_rbar && (ridx[IDX_W-1:0] == IDX_W'(i));
    end

    mpu_region_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .idx_i        (IDX_W'(i)),
      .wr_i         (cell_wr[i]),
      .start_addr_i (addr_q),
      .end_addr_i   (end_q),
      .carrier_i    (chain[i+1]),
      .carrier_o    (chain[i]),
      .base_o       (base_w[i]),
      .limit_o      (limit_w[i])
    );
  end

  assign fin = chain[0].valid;

  // region and alias decode
  always_comb begin
    is_region = 1'b0;
    is_rbar   = 1'b0;
    alias_off = 2'd0;
    unique case (sel_q) inside
      SEL_RBAR, SEL_RLAR: begin
        is_region = 1'b1;
        alias_off = 2'd0;
      end
      SEL_RBAR_A1, SEL_RLAR_A1: begin
        is_region = 1'b1;
        alias_off = 2'd1;
      end
      SEL_RBAR_A2, SEL_RLAR_A2: begin
        is_region = 1'b1;
        alias_off = 2'd2;
      end
      SEL_RBAR_A3, SEL_RLAR_A3: begin
        is_region = 1'b1;
        alias_off = 2'd3;
      end
      default: begin
        is_region = 1'b0;
      end
    endcase
    unique case (sel_q) inside
      SEL_RBAR, SEL_RBAR_A1, SEL_RBAR_A2, SEL_RBAR_A3: is_rbar = 1'b1;
      default:                                         is_rbar = 1'b0;
    endcase
  end

  assign ridx    = {2'b00, rnr_q} + {{IDX_W{1'b0}}, alias_off};
  assign ridx_ok = (ridx < RC_EXT);

  always_comb begin
    region_rd = '0;
    for (int k = 0; k < REGION_COUNT; k++) begin
      if (ridx[IDX_W-1:0] == IDX_W'(k)) begin
        region_rd = is_rbar ? base_w[k] : limit_w[k];
      end
    end
  end

  always_comb begin
    rd_word = '0;
    if (is_region) begin
      rd_word = ridx_ok ? region_rd : 32'd0;
    end else begin
      unique case (sel_q)
        SEL_TYPE:  rd_word = 32'(REGION_COUNT) << 8;
        SEL_CTRL:  rd_word = {29'b0, ctrl_q};
        SEL_RNR:   rd_word = 32'(rnr_q);
        SEL_MAIR0: rd_word = mair0_q;
        SEL_MAIR1: rd_word = mair1_q;
        default:   rd_word = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q  <= '0;
      rnr_q   <= '0;
      mair0_q <= '0;
      mair1_q <= '0;
    end else if (reg_op_q && (cmd_q == CMD_WRITE) && !is_region) begin
      unique case (sel_q)
        SEL_CTRL: ctrl_q <= data_q[2:0];
        SEL_RNR: begin
          if (data_q < 32'(REGION_COUNT)) begin
            rnr_q <= data_q[IDX_W-1:0];
          end
        end
        SEL_MAIR0: mair0_q <= data_q;
        SEL_MAIR1: mair1_q <= data_q;
        default: begin
        end
      endcase
    end
  end

  // check resolution from the record leaving the lowest cell
  assign bypass = !ctrl_q[0] || (hf_q && !ctrl_q[1]);
  assign ok0    = mpu_byte_ok(chain[0].hit0, chain[0].perm0, fetch_q, priv_q, wr_q,
                              addr_q < CODE_LIMIT, ctrl_q[2]);
  assign ok1    = mpu_byte_ok(chain[0].hit1, chain[0].perm1, fetch_q, priv_q, wr_q,
                              end_q < CODE_LIMIT, ctrl_q[2]);
  assign spans  = (chain[0].hit0 != chain[0].hit1) ||
                  (chain[0].hit0 && (chain[0].idx0 != chain[0].idx1));

  always_comb begin
    if (bypass) begin
      check_ok = 1'b1;
    end else if (size_zero_q || wrap_q) begin
      check_ok = 1'b0;
    end else if (!size_one_q && spans) begin
      check_ok = ok0 && ok1;
    end else begin
      check_ok = ok0;
    end
  end

  assign mair_word  = chain[0].attr0[2] ? mair1_q : mair0_q;
  assign mair_shift = mair_word >> {chain[0].attr0[1:0], 3'b000};
  assign attr_byte  = (ctrl_q[0] && chain[0].hit0) ? (mair_shift[7:0] & BYTE_MASK) : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= fin || reg_op_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin) begin
      allowed_q <= check_ok;
      ftype_q   <= check_ok ? FAULT_NONE : (fetch_q ? FAULT_INSTR : FAULT_DATA);
      faddr_q   <= check_ok ? 32'd0 : addr_q;
      fvalid_q  <= !check_ok;
      rdata_q   <= '0;
      attr_q    <= attr_byte;
    end else if (reg_op_q) begin
      allowed_q <= 1'b0;
      ftype_q   <= FAULT_NONE;
      faddr_q   <= '0;
      fvalid_q  <= 1'b0;
      rdata_q   <= (cmd_q == CMD_READ) ? rd_word : 32'd0;
      attr_q    <= '0;
    end
  end

  assign result_valid_o        = res_valid_q;
  assign allowed_o             = allowed_q;
  assign fault_type_o          = ftype_q;
  assign fault_address_o       = faddr_q;
  assign fault_address_valid_o = fvalid_q;
  assign read_data_o           = rdata_q;
  assign attribute_byte_o      = attr_q;

  a_result_frees_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while unit still busy");

  a_record_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |-> busy_q && (cmd_q == CMD_CHECK))
    else $error("match record left the cell row with no check pending");

  a_allowed_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && allowed_o) |-> (fault_type_o == FAULT_NONE) && !fault_address_valid_o)
    else $error("allowed access reports a fault");

endmodule
